@@ hdl/qssd_pkg.sv @@
// ============================================================================
// qssd_pkg
// Shared types, character codes and helpers for the query string splitter.
// ============================================================================
package qssd_pkg;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEquals  = 8'h3D;

  localparam int MaxResults = 4;
  localparam int CntW       = $clog2(MaxResults + 1);

  typedef struct packed {
    logic       at_string_start;
    logic       value_part_active;
    logic       percent_pending;
    logic       held_digit_valid;
    logic [7:0] held_digit;
  } qssd_state_t;

  localparam qssd_state_t StateReset = '{
    at_string_start:   1'b1,
    value_part_active: 1'b0,
    percent_pending:   1'b0,
    held_digit_valid:  1'b0,
    held_digit:        8'h00
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       in_value_part;
    logic       entry_done;
    logic       entry_had_equals;
    logic       query_done;
  } qssd_result_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       string_end;
  } qssd_item_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic qssd_result_t mk_data(input logic [7:0] b, input logic vp);
    qssd_result_t r;
    r = '0;
    r.out_byte       = b;
    r.out_byte_valid = 1'b1;
    r.in_value_part  = vp;
    return r;
  endfunction

  function automatic qssd_result_t mk_marker(input logic eq, input logic qd);
    qssd_result_t r;
    r = '0;
    r.entry_done       = 1'b1;
    r.entry_had_equals = eq;
    r.query_done       = qd;
    return r;
  endfunction

endpackage

@@ hdl/query_string_splitter_decoder_core.sv @@
// ============================================================================
// query_string_splitter_decoder_core
// Splits a query string into key/value entries and decodes each part.
// ============================================================================
// Channel  Dir  Contents
// s_axis   in   tdata: in_byte; tuser: byte_present; tlast: string_end
// m_axis   out  tdata: out_byte, entry_done, entry_had_equals, query_done;
//               tuser: out_byte_valid, in_value_part; tlast: run_last
//
// An item waits in the input register, where it is decoded, and is loaded
// into the result register once that register is free. Its results then
// leave one per cycle while m_axis_tready is high; the next item is loaded
// as the last one is taken, and an item with no result leaves nothing.
// Reset is synchronous and empties both registers. Either side may stall at
// any time without loss.
module query_string_splitter_decoder_core
  import qssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] entry_done,
                                      // [9] entry_had_equals, [10] query_done
  output logic [1:0]  m_axis_tuser,   // [0] out_byte_valid, [1] in_value_part
  output logic        m_axis_tlast
);

  qssd_item_t      item;
  logic            item_valid;
  qssd_state_t     st;
  qssd_state_t     st_next;
  qssd_result_t    dec_res [MaxResults];
  logic [CntW-1:0] dec_cnt;
  logic            can_load;
  logic            load;
  qssd_result_t    out_res;

  assign load          = item_valid && can_load;
  assign s_axis_tready = !item_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.in_byte      <= s_axis_tdata;
      item.byte_present <= s_axis_tuser;
      item.string_end   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
    end else if (load) begin
      st <= st_next;
    end
  end

  qssd_decode u_decode (
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .res     (dec_res),
    .res_cnt (dec_cnt)
  );

  qssd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_res  (dec_res),
    .load_cnt  (dec_cnt),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_res.query_done, out_res.entry_had_equals,
                         out_res.entry_done, out_res.out_byte};
  assign m_axis_tuser = {out_res.in_value_part, out_res.out_byte_valid};

endmodule

@@ hdl/qssd_decode.sv @@
// ============================================================================
// qssd_decode
// Works out all results of one input item and the next parser state.
// ============================================================================
module qssd_decode
  import qssd_pkg::*;
(
  input  qssd_item_t   item,
  input  qssd_state_t  st,
  output qssd_state_t  st_next,
  output qssd_result_t res [MaxResults],
  output logic [CntW-1:0] res_cnt
);

  always_comb begin
    qssd_state_t  s;
    logic [CntW-1:0] n;
    logic [4:0]   h;
    logic [4:0]   hh;
    logic         ending;
    logic         do_data;
    logic         do_fresh;
    logic         do_flush;
    s = st;
    n = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end
    h        = hex_of(item.in_byte);
    hh       = hex_of(st.held_digit);
    ending   = item.string_end || !item.byte_present;
    do_data  = 1'b0;
    do_fresh = 1'b0;
    do_flush = 1'b0;

    if (item.byte_present) begin
      if (st.at_string_start && item.in_byte == ChQuest) begin
        s.at_string_start = 1'b0;
      end else begin
        s.at_string_start = 1'b0;
        if (item.in_byte == ChAmp || (item.in_byte == ChEquals && !st.value_part_active)) begin
          do_flush = 1'b1;
        end else begin
          do_data = 1'b1;
          if (!st.percent_pending) begin
            do_fresh = 1'b1;
          end else if (!st.held_digit_valid) begin
            if (h[4]) begin
              s.held_digit       = item.in_byte;
              s.held_digit_valid = 1'b1;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end else if (h[4]) begin
            s.percent_pending  = 1'b0;
            s.held_digit_valid = 1'b0;
            s.held_digit       = 8'h00;
            res[n[1:0]] = mk_data({hh[3:0], h[3:0]}, s.value_part_active);
            n = n + CntW'(1);
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
      end
    end

    if (do_flush && s.percent_pending) begin
      res[n[1:0]] = mk_data(ChPercent, s.value_part_active);
      n = n + CntW'(1);
      if (s.held_digit_valid) begin
        res[n[1:0]] = mk_data(s.held_digit, s.value_part_active);
        n = n + CntW'(1);
      end
    end
    if (do_flush) begin
      s.percent_pending  = 1'b0;
      s.held_digit_valid = 1'b0;
      s.held_digit       = 8'h00;
    end

    if (do_fresh) begin
      if (item.in_byte == ChPercent) begin
        s.percent_pending  = 1'b1;
        s.held_digit_valid = 1'b0;
      end else if (item.in_byte == ChPlus) begin
        res[n[1:0]] = mk_data(ChSpace, s.value_part_active);
        n = n + CntW'(1);
      end else begin
        res[n[1:0]] = mk_data(item.in_byte, s.value_part_active);
        n = n + CntW'(1);
      end
    end

    if (item.byte_present && !do_data && do_flush) begin
      if (item.in_byte == ChAmp) begin
        res[n[1:0]] = mk_marker(s.value_part_active, 1'b0);
        n = n + CntW'(1);
        s.value_part_active = 1'b0;
      end else begin
        s.value_part_active = 1'b1;
      end
    end

    if (ending) begin
      if (s.percent_pending) begin
        res[n[1:0]] = mk_data(ChPercent, s.value_part_active);
        n = n + CntW'(1);
        if (s.held_digit_valid) begin
          res[n[1:0]] = mk_data(s.held_digit, s.value_part_active);
          n = n + CntW'(1);
        end
      end
      res[n[1:0]] = mk_marker(s.value_part_active, 1'b1);
      n = n + CntW'(1);
      s = StateReset;
    end

    st_next = s;
    res_cnt = n;
  end

endmodule

@@ hdl/qssd_out_queue.sv @@
// ============================================================================
// qssd_out_queue
// Result register for one item's burst of results, drained one per cycle while out_ready is high.
// ============================================================================
module qssd_out_queue
  import qssd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  qssd_result_t    load_res [MaxResults],
  input  logic [CntW-1:0] load_cnt,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output qssd_result_t    out_res,
  output logic            out_last
);

  qssd_result_t    res [MaxResults];
  logic [CntW-1:0] cnt;
  logic            take;

  assign take      = out_valid && out_ready;
  assign out_valid = cnt != '0;
  assign out_res   = res[0];
  assign out_last  = cnt == CntW'(1);
  assign can_load  = (cnt == '0) || (out_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (take) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res[i] <= res[i + 1];
      end
    end
  end

endmodule

@@ test/query_string_splitter_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// query_string_splitter_decoder_core_tb
// Streams query strings into the splitter and checks every decoded byte and
// entry marker against a cycle-free model of the decoder, under random stalls
// on both sides and one long back-pressure stretch on the output.
// ============================================================================
module query_string_splitter_decoder_core_tb;
  import qssd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       value_side;
    logic       closes_entry;
    logic       had_equals;
    logic       closes_query;
    logic       last_of_request;
  } decoded_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  qssd_item_t    pending_q[$];
  decoded_item_t expected_q[$];
  decoded_item_t step_q[$];

  // Decoder state as seen between requests.
  logic       at_start    = 1'b1;
  logic       in_value    = 1'b0;
  logic       pct_pending = 1'b0;
  logic       digit_held  = 1'b0;
  logic [7:0] held_char   = 8'h00;

  int  mismatches     = 0;
  int  requests_taken = 0;
  int  send_gap       = 0;
  int  sink_gap       = 0;
  bit  req_taken      = 1'b0;
  bit  holding_off    = 1'b0;

  query_string_splitter_decoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    decoded_item_t r;
    r = '0;
    r.data       = b;
    r.data_valid = 1'b1;
    r.value_side = in_value;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic emit_marker(input logic query_end);
    decoded_item_t r;
    r = '0;
    r.closes_entry = 1'b1;
    r.had_equals   = in_value;
    r.closes_query = query_end;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic cut_escape();
    if (pct_pending) begin
      emit_byte(ChPercent);
      if (digit_held) emit_byte(held_char);
    end
    pct_pending = 1'b0;
    digit_held  = 1'b0;
    held_char   = 8'h00;
  endtask

  task automatic plain_byte(input logic [7:0] c);
    if (c == ChPercent) begin
      pct_pending = 1'b1;
      digit_held  = 1'b0;
    end else if (c == ChPlus) begin
      emit_byte(ChSpace);
    end else begin
      emit_byte(c);
    end
  endtask

  task automatic body_byte(input logic [7:0] c);
    int lo;
    int hi;
    lo = nibble_of(c);
    if (!pct_pending) begin
      plain_byte(c);
    end else if (lo < 0) begin
      cut_escape();
      plain_byte(c);
    end else if (!digit_held) begin
      held_char  = c;
      digit_held = 1'b1;
    end else begin
      hi = nibble_of(held_char);
      pct_pending = 1'b0;
      digit_held  = 1'b0;
      held_char   = 8'h00;
      emit_byte({hi[3:0], lo[3:0]});
    end
  endtask

  task automatic predict_request(input logic [7:0] c, input logic present, input logic str_end);
    decoded_item_t r;
    step_q.delete();
    if (present) begin
      if (at_start && c == ChQuest) begin
        at_start = 1'b0;
      end else begin
        at_start = 1'b0;
        if (c == ChAmp) begin
          cut_escape();
          emit_marker(1'b0);
          in_value = 1'b0;
        end else if (c == ChEquals && !in_value) begin
          cut_escape();
          in_value = 1'b1;
        end else begin
          body_byte(c);
        end
      end
    end
    if (str_end || !present) begin
      cut_escape();
      emit_marker(1'b1);
      at_start = 1'b1;
      in_value = 1'b0;
    end
    for (int i = 0; i < step_q.size(); i++) begin
      r = step_q[i];
      r.last_of_request = (i == step_q.size() - 1);
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    decoded_item_t got;
    decoded_item_t want;
    got.data            = m_axis_tdata[7:0];
    got.closes_entry    = m_axis_tdata[8];
    got.had_equals      = m_axis_tdata[9];
    got.closes_query    = m_axis_tdata[10];
    got.data_valid      = m_axis_tuser[0];
    got.value_side      = m_axis_tuser[1];
    got.last_of_request = m_axis_tlast;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result, tdata", int'(m_axis_tdata), 0);
    end else begin
      want = expected_q.pop_front();
      if (got.data != want.data)
        report_mismatch("out_byte", int'(got.data), int'(want.data));
      if (got.data_valid != want.data_valid)
        report_mismatch("out_byte_valid", int'(got.data_valid), int'(want.data_valid));
      if (got.value_side != want.value_side)
        report_mismatch("in_value_part", int'(got.value_side), int'(want.value_side));
      if (got.closes_entry != want.closes_entry)
        report_mismatch("entry_done", int'(got.closes_entry), int'(want.closes_entry));
      if (got.had_equals != want.had_equals)
        report_mismatch("entry_had_equals", int'(got.had_equals), int'(want.had_equals));
      if (got.closes_query != want.closes_query)
        report_mismatch("query_done", int'(got.closes_query), int'(want.closes_query));
      if (got.last_of_request != want.last_of_request)
        report_mismatch("run_last", int'(got.last_of_request),
                        int'(want.last_of_request));
    end
  endtask

  // Results are checked before the new request is predicted; a result can
  // never belong to a request taken on the same edge.
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        req_taken = 1'b1;
        requests_taken++;
        predict_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
    end
  end

  always @(negedge clk) begin
    qssd_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        s_axis_tdata  <= it.in_byte;
        s_axis_tuser  <= it.byte_present;
        s_axis_tlast  <= it.string_end;
        s_axis_tvalid <= 1'b1;
        if (pending_q.size() >= 40 && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (holding_off) begin
      m_axis_tready <= 1'b0;
    end else if (pending_q.size() >= 40 && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One long output stall while requests keep coming, so the core backs up.
  initial begin
    wait (requests_taken >= 60);
    @(posedge clk);
    holding_off = 1'b1;
    repeat (100) @(posedge clk);
    holding_off = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("query_string_splitter_decoder_core: mismatch");
    $finish;
  end

  task automatic push_item(input logic [7:0] b, input logic present, input logic str_end);
    qssd_item_t it;
    it.in_byte      = b;
    it.byte_present = present;
    it.string_end   = str_end;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic push_text(input string s, input bit end_on_last);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, end_on_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_hex_char();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'(int'("0") + n);
    if (n < 16) return 8'(int'("a") + n - 10);
    return 8'(int'("A") + n - 16);
  endfunction

  function automatic logic [7:0] random_query_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return random_hex_char();
    if (r < 45) return 8'($urandom_range(int'("g"), int'("z")));
    if (r < 55) return ChPercent;
    if (r < 62) return ChPlus;
    if (r < 70) return ChEquals;
    if (r < 78) return ChAmp;
    if (r < 82) return ChQuest;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] text[$];
    int         len;
    // Empty string from a bare end request; its byte must be ignored.
    push_item(8'hFF, 1'b0, 1'b1);
    // Leading question mark, mixed-case escapes, plus, a percent after a percent.
    push_text("?%4A+=%%3f", 1'b1);
    // Escapes cut by an ampersand and by the first equals, a later question
    // mark and equals taken as data.
    push_text("%4&?%5=%=", 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    // Empty fields, then a held digit flushed by a bad byte at the end.
    push_text("&&%4z", 1'b1);
    push_item(8'h00, 1'b1, 1'b1);

    while (pending_q.size() < 165) begin
      text.delete();
      len = $urandom_range(0, 12);
      while (text.size() < len) begin
        if ($urandom_range(0, 6) == 0) begin
          text.insert(text.size(), ChPercent);
          text.insert(text.size(), random_hex_char());
          text.insert(text.size(), random_hex_char());
        end else begin
          text.insert(text.size(), random_query_char());
        end
      end
      if (text.size() == 0 || $urandom_range(0, 1) == 0) begin
        foreach (text[i]) push_item(text[i], 1'b1, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        foreach (text[i]) push_item(text[i], 1'b1, i == text.size() - 1);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("query_string_splitter_decoder_core: match");
    end else begin
      $display("query_string_splitter_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
